### src/buddy_block_allocator_macros.svh
// Assertion macros shared by the buddy allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bba_pkg.sv
// Shared types and codes for the buddy allocator.
// No dependencies; imported by bba_pool and buddy_block_allocator.
package bba_pkg;

  localparam int WORD_BITS = 32;
  localparam int ORDER_W   = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_ZERO      = 3'd1;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd2;
  localparam logic [2:0] STAT_NO_MEM    = 3'd3;
  localparam logic [2:0] STAT_BAD_FREE  = 3'd4;

  // command from the front end to one pool
  typedef struct packed {
    logic                 start;
    logic                 op;
    logic [ORDER_W-1:0]   order;
    logic [31:0]          off;
  } pool_cmd_t;

  // pool status back to the front end
  typedef struct packed {
    logic        ready;
    logic        done;
    logic        ok;
    logic [31:0] off;
  } pool_rsp_t;

endpackage

### src/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for free maps and order tables.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bba_pool.sv
// One buddy pool: free-map RAM (heap order, 32 nodes a word) and order RAM.
// Depends on bba_pkg and bba_ram.
module bba_pool import bba_pkg::*; #(
  parameter int LO = 5,
  parameter int HI = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  pool_cmd_t cmd,
  output pool_rsp_t rsp
);

  localparam int LV    = HI - LO + 1;
  localparam int NW    = LV;
  localparam int WN    = (LV > 5) ? (1 << (LV - 5)) : 1;
  localparam int AW    = (WN > 1) ? $clog2(WN) : 1;
  localparam int SLOTS = 1 << (HI - LO);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLRN  = (WN > SLOTS) ? WN : SLOTS;
  localparam int CW    = $clog2(CLRN) + 1;

  localparam logic [3:0] P_CLR   = 4'd0;
  localparam logic [3:0] P_IDLE  = 4'd1;
  localparam logic [3:0] P_SRD   = 4'd2;
  localparam logic [3:0] P_SEV   = 4'd3;
  localparam logic [3:0] P_XRD   = 4'd4;
  localparam logic [3:0] P_XWR   = 4'd5;
  localparam logic [3:0] P_ORDW  = 4'd6;
  localparam logic [3:0] P_FCHK  = 4'd7;
  localparam logic [3:0] P_MRD   = 4'd8;
  localparam logic [3:0] P_MEV   = 4'd9;
  localparam logic [3:0] P_SETRD = 4'd10;
  localparam logic [3:0] P_SETWR = 4'd11;

  logic [3:0]         state;
  logic [CW-1:0]      cnt;
  logic [ORDER_W-1:0] k;
  logic [ORDER_W-1:0] order;
  logic [AW-1:0]      w;
  logic [NW-1:0]      node;
  logic [31:0]        off_r;
  logic               done;
  logic               done_next;
  logic               ok;
  logic [31:0]        roff;

  logic               fm_we;
  logic [AW-1:0]      fm_waddr;
  logic [31:0]        fm_wdata;
  logic [AW-1:0]      fm_raddr;
  logic [31:0]        fm_rdata;
  logic               od_we;
  logic [SW-1:0]      od_waddr;
  logic [ORDER_W-1:0] od_wdata;
  logic [SW-1:0]      od_raddr;
  logic [ORDER_W-1:0] od_rdata;

  // node count of a level
  function automatic logic [31:0] lvl_n(input logic [ORDER_W-1:0] kk);
    logic [ORDER_W-1:0] d;
    d = ORDER_W'(HI) - kk;
    return 32'd1 << d;
  endfunction

  function automatic logic [AW-1:0] waddr_of(input logic [NW-1:0] n);
    logic [31:0] x;
    x = 32'(n);
    return AW'(x >> 5);
  endfunction

  function automatic logic [31:0] bit_of(input logic [NW-1:0] n);
    logic [31:0] x;
    x = 32'(n);
    return 32'd1 << x[4:0];
  endfunction

  function automatic logic [AW-1:0] wstart_of(input logic [ORDER_W-1:0] kk);
    logic [31:0] n;
    n = lvl_n(kk);
    return (n >= 32'd32) ? AW'(n >> 5) : '0;
  endfunction

  function automatic logic [AW-1:0] wend_of(input logic [ORDER_W-1:0] kk);
    logic [31:0] n;
    n = lvl_n(kk);
    return (n >= 32'd32) ? AW'((n >> 4) - 32'd1) : '0;
  endfunction

  // levels narrower than a word share word 0 at bits [n, 2n)
  function automatic logic [31:0] mask_of(input logic [ORDER_W-1:0] kk);
    logic [31:0] n;
    logic [63:0] t;
    n = lvl_n(kk);
    t = ((64'd1 << (n << 1)) - 64'd1) & ~((64'd1 << n) - 64'd1);
    return (n >= 32'd32) ? '1 : t[31:0];
  endfunction

  logic [31:0]        masked;
  logic               hit;
  logic [4:0]         hit_i;
  logic [NW-1:0]      hit_node;
  logic [NW-1:0]      child;
  logic [NW-1:0]      bud;
  logic               bud_set;
  logic [31:0]        aoff;
  logic               kvalid;
  logic [NW-1:0]      fnode;

  // scan evaluation: lowest free node in the current word
  always_comb begin
    masked = fm_rdata & mask_of(k);
    hit    = |masked;
    hit_i  = '0;
    for (int i = 31; i >= 0; i--) begin
      if (masked[i]) begin
        hit_i = 5'(i);
      end
    end
    hit_node = NW'((32'(w) << 5) | 32'(hit_i));
  end

  // split, merge and free-check helpers
  always_comb begin
    child   = NW'((32'(node) << 1) | 32'd1);
    bud     = node ^ NW'(1);
    bud_set = |(fm_rdata & bit_of(bud));
    aoff    = 32'(32'(node) ^ lvl_n(order)) << order;
    kvalid  = (od_rdata >= ORDER_W'(LO)) && (od_rdata <= ORDER_W'(HI)) &&
              ((off_r & ((32'd1 << od_rdata) - 32'd1)) == 32'd0);
    fnode   = NW'(lvl_n(od_rdata) | (off_r >> od_rdata));
  end

  // completion of a pool operation
  always_comb begin
    unique case (state)
      P_SEV:   done_next = !hit && (w == wend_of(k)) && (k == ORDER_W'(HI));
      P_ORDW:  done_next = 1'b1;
      P_FCHK:  done_next = !kvalid;
      P_MEV:   done_next = !bud_set;
      P_SETWR: done_next = 1'b1;
      default: done_next = 1'b0;
    endcase
  end

  // free-map read address
  always_comb begin
    unique case (state)
      P_XRD:   fm_raddr = waddr_of(child);
      P_MRD:   fm_raddr = waddr_of(bud);
      P_SETRD: fm_raddr = waddr_of(node);
      default: fm_raddr = w;
    endcase
  end

  // free-map write port
  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = w;
    fm_wdata = fm_rdata;
    unique case (state)
      P_CLR: begin
        fm_we    = cnt < CW'(WN);
        fm_waddr = AW'(cnt);
        fm_wdata = (cnt == '0) ? 32'h2 : 32'h0;
      end
      P_SEV: begin
        fm_we    = hit;
        fm_wdata = fm_rdata & ~(32'd1 << hit_i);
      end
      P_XWR: begin
        fm_we    = 1'b1;
        fm_waddr = waddr_of(child);
        fm_wdata = fm_rdata | bit_of(child);
      end
      P_MEV: begin
        fm_we    = 1'b1;
        fm_waddr = waddr_of(bud);
        fm_wdata = bud_set ? (fm_rdata & ~bit_of(bud)) : (fm_rdata | bit_of(node));
      end
      P_SETWR: begin
        fm_we    = 1'b1;
        fm_waddr = waddr_of(node);
        fm_wdata = fm_rdata | bit_of(node);
      end
      default: fm_we = 1'b0;
    endcase
  end

  // order table ports
  always_comb begin
    od_raddr = SW'(cmd.off >> LO);
    od_we    = 1'b0;
    od_waddr = SW'(off_r >> LO);
    od_wdata = '0;
    unique case (state)
      P_CLR: begin
        od_we    = cnt < CW'(SLOTS);
        od_waddr = SW'(cnt);
      end
      P_ORDW: begin
        od_we    = 1'b1;
        od_waddr = SW'(aoff >> LO);
        od_wdata = order;
      end
      P_FCHK:  od_we = kvalid;
      default: od_we = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_CLR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        P_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(CLRN - 1)) begin
            state <= P_IDLE;
          end
        end
        P_IDLE: begin
          if (cmd.start) begin
            order <= cmd.order;
            off_r <= cmd.off;
            if (cmd.op == OP_ALLOC) begin
              k     <= cmd.order;
              w     <= wstart_of(cmd.order);
              state <= P_SRD;
            end else begin
              state <= P_FCHK;
            end
          end
        end
        P_SRD: state <= P_SEV;
        P_SEV: begin
          if (hit) begin
            node  <= hit_node;
            state <= (k == order) ? P_ORDW : P_XRD;
          end else if (w == wend_of(k)) begin
            if (k == ORDER_W'(HI)) begin
              ok    <= 1'b0;
              state <= P_IDLE;
            end else begin
              k     <= k + ORDER_W'(1);
              w     <= wstart_of(k + ORDER_W'(1));
              state <= P_SRD;
            end
          end else begin
            w     <= w + AW'(1);
            state <= P_SRD;
          end
        end
        P_XRD: state <= P_XWR;
        P_XWR: begin
          node  <= NW'(32'(node) << 1);
          k     <= k - ORDER_W'(1);
          state <= (k - ORDER_W'(1) == order) ? P_ORDW : P_XRD;
        end
        P_ORDW: begin
          ok    <= 1'b1;
          roff  <= aoff;
          state <= P_IDLE;
        end
        P_FCHK: begin
          if (!kvalid) begin
            ok    <= 1'b0;
            state <= P_IDLE;
          end else begin
            k     <= od_rdata;
            node  <= fnode;
            state <= (od_rdata == ORDER_W'(HI)) ? P_SETRD : P_MRD;
          end
        end
        P_MRD: state <= P_MEV;
        P_MEV: begin
          if (bud_set) begin
            node  <= node >> 1;
            k     <= k + ORDER_W'(1);
            state <= (k + ORDER_W'(1) == ORDER_W'(HI)) ? P_SETRD : P_MRD;
          end else begin
            ok    <= 1'b1;
            state <= P_IDLE;
          end
        end
        P_SETRD: state <= P_SETWR;
        P_SETWR: begin
          ok    <= 1'b1;
          state <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.ready = (state == P_IDLE);
    rsp.done  = done;
    rsp.ok    = ok;
    rsp.off   = roff;
  end

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(WN)) u_fmap (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  bba_ram #(.WIDTH(ORDER_W), .DEPTH(SLOTS)) u_order (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_waddr),
    .wdata (od_wdata),
    .raddr (od_raddr),
    .rdata (od_rdata)
  );

endmodule

### src/buddy_block_allocator.sv
// Channel   Signals                          Direction
// request   in_valid/in_stall, req_type,     in
//           size, addr
// result    out_valid/out_stall, block_addr, out
//           status
// config    APB: psel penable pwrite paddr   in/out
//
// One request at a time. A decode state after acceptance starts a pool;
// error cases skip the pool. An alloc scans one 32-node free-map word at
// a time (RAM read, then write-back), splits level by level (read, then
// write) and records the order. A free checks the order table, probes
// buddies for merging (read, then write-back) and sets the whole-pool bit
// when merging reaches the top. The result is registered, then moved to
// the output register, which holds a stalled result while the next request
// runs. After reset a clearing pass over max(slots, free-map words) entries
// per pool holds in_stall high. Depends on bba_pkg, bba_pool, macros header.
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator import bba_pkg::*; #(
  parameter int SMALL_MIN_ORDER = 5,
  parameter int SMALL_MAX_ORDER = 16,
  parameter int PAGE_MIN_ORDER  = 12,
  parameter int PAGE_MAX_ORDER  = 20,
  parameter int HEADER_BYTES    = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] size,
  input  logic [31:0] addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] block_addr,
  output logic [2:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  localparam logic       REG_BASE   = 1'b0;
  localparam logic [31:0] HDR        = 32'(HEADER_BYTES);
  localparam logic [31:0] SMALL_SPAN = 32'(64'd1 << SMALL_MAX_ORDER);
  localparam logic [31:0] PAGE_SPAN  = 32'(64'd1 << PAGE_MAX_ORDER);
  localparam logic [31:0] SMALL_MASK = 32'((64'd1 << SMALL_MIN_ORDER) - 64'd1);
  localparam logic [31:0] PAGE_ALIGN = 32'((64'd1 << PAGE_MIN_ORDER) - 64'd1);

  logic [1:0]  st;
  logic [31:0] base;
  logic        rq_type;
  logic [31:0] rq_size;
  logic [31:0] rq_addr;
  logic        sel;
  logic [31:0] res_addr;
  logic [2:0]  res_status;

  pool_cmd_t   cmd0, cmd1;
  pool_rsp_t   rsp0, rsp1, rsp;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BASE) ? base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_BASE) begin
      base <= pwdata;
    end
  end

  // request decode
  logic [32:0]        total;
  logic [5:0]         bl;
  logic [5:0]         ordc;
  logic [31:0]        rel;
  logic [31:0]        rel_pg;
  logic               d_launch;
  logic               d_sel;
  logic [ORDER_W-1:0] d_order;
  logic [31:0]        d_off;
  logic [2:0]         d_status;

  always_comb begin
    total = 33'(rq_size) + 33'(HDR);
    bl    = '0;
    for (int i = 0; i < 33; i++) begin
      if (total[i]) begin
        bl = 6'(i + 1);
      end
    end
    ordc     = (bl < 6'(SMALL_MIN_ORDER)) ? 6'(SMALL_MIN_ORDER) : bl;
    rel      = rq_addr - base - HDR;
    rel_pg   = rel - SMALL_SPAN;
    d_launch = 1'b0;
    d_sel    = 1'b0;
    d_order  = ORDER_W'(ordc);
    d_off    = rel;
    d_status = STAT_OK;
    if (rq_type == OP_ALLOC) begin
      if (rq_size == 32'd0) begin
        d_status = STAT_ZERO;
      end else if (ordc > 6'(PAGE_MAX_ORDER)) begin
        d_status = STAT_TOO_LARGE;
      end else if (ordc < 6'(PAGE_MIN_ORDER)) begin
        if (ordc > 6'(SMALL_MAX_ORDER)) begin
          d_status = STAT_NO_MEM;
        end else begin
          d_launch = 1'b1;
        end
      end else begin
        d_launch = 1'b1;
        d_sel    = 1'b1;
      end
    end else begin
      if (rel < SMALL_SPAN) begin
        if ((rel & SMALL_MASK) != 32'd0) begin
          d_status = STAT_BAD_FREE;
        end else begin
          d_launch = 1'b1;
        end
      end else if (rel_pg < PAGE_SPAN) begin
        d_off = rel_pg;
        if ((rel_pg & PAGE_ALIGN) != 32'd0) begin
          d_status = STAT_BAD_FREE;
        end else begin
          d_launch = 1'b1;
          d_sel    = 1'b1;
        end
      end else begin
        d_status = STAT_BAD_FREE;
      end
    end
  end

  // pool commands
  always_comb begin
    cmd0.start = (st == ST_DEC) && d_launch && !d_sel;
    cmd0.op    = rq_type;
    cmd0.order = d_order;
    cmd0.off   = d_off;
    cmd1.start = (st == ST_DEC) && d_launch && d_sel;
    cmd1.op    = rq_type;
    cmd1.order = d_order;
    cmd1.off   = d_off;
    rsp        = sel ? rsp1 : rsp0;
  end

  assign in_stall = !((st == ST_IDLE) && rsp0.ready && rsp1.ready);

  // request sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && st != ST_RES) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            rq_type <= req_type;
            rq_size <= size;
            rq_addr <= addr;
            st      <= ST_DEC;
          end
        end
        ST_DEC: begin
          sel <= d_sel;
          if (d_launch) begin
            st <= ST_WAIT;
          end else begin
            res_status <= d_status;
            res_addr   <= 32'd0;
            st         <= ST_RES;
          end
        end
        ST_WAIT: begin
          if (rsp.done) begin
            if (rsp.ok) begin
              res_status <= STAT_OK;
            end else begin
              res_status <= (rq_type == OP_ALLOC) ? STAT_NO_MEM : STAT_BAD_FREE;
            end
            res_addr <= (rsp.ok && rq_type == OP_ALLOC) ?
                        base + (sel ? SMALL_SPAN : 32'd0) + rsp.off + HDR : 32'd0;
            st <= ST_RES;
          end
        end
        ST_RES: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            block_addr <= res_addr;
            status     <= res_status;
            st         <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  bba_pool #(.LO(SMALL_MIN_ORDER), .HI(SMALL_MAX_ORDER)) u_small (
    .clk (clk),
    .rst (rst),
    .cmd (cmd0),
    .rsp (rsp0)
  );

  bba_pool #(.LO(PAGE_MIN_ORDER), .HI(PAGE_MAX_ORDER)) u_page (
    .clk (clk),
    .rst (rst),
    .cmd (cmd1),
    .rsp (rsp1)
  );

  // checks
  `BBA_ASSERT_IMP(a_err_addr_zero, clk, rst, out_valid && status != STAT_OK, block_addr == 32'd0, "error result with nonzero address")
  `BBA_ASSERT_NEXT(a_accept_decode, clk, rst, in_valid && !in_stall, st == ST_DEC, "accepted request not decoded")
  `BBA_ASSERT_IMP(a_done_in_wait, clk, rst, rsp0.done || rsp1.done, st == ST_WAIT, "pool done outside wait")
  `BBA_ASSERT_IMP(a_one_start, clk, rst, cmd0.start || cmd1.start, !(cmd0.start && cmd1.start) && rsp0.ready && rsp1.ready, "pool started while busy")

endmodule

### test/buddy_block_allocator_tb.sv
// Self-checking testbench for the two-pool buddy allocator.
// Depends on bba_pkg and buddy_block_allocator; an allocator model in a
// scoreboard class predicts every result.
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int SM_LO = 5, SM_HI = 16, PG_LO = 12, PG_HI = 20, HDR = 12;
  localparam int SM_NODES = (1 << (SM_HI - SM_LO + 1)) - 1;
  localparam int PG_NODES = (1 << (PG_HI - PG_LO + 1)) - 1;
  localparam int SM_SLOTS = 1 << (SM_HI - SM_LO);
  localparam int PG_SLOTS = 1 << (PG_HI - PG_LO);
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0] blk;
    logic [2:0]  stat;
  } alloc_result_t;

  // allocator model plus queue of predicted results
  class alloc_scoreboard;
    bit          free_bit[SM_NODES + PG_NODES];
    bit [4:0]    order_of[SM_SLOTS + PG_SLOTS];
    logic [31:0] base;
    logic [31:0] live_rel[$];
    logic [31:0] last_freed;
    alloc_result_t pending_q[$];
    int fails;

    function new();
      base = 0;
      fails = 0;
      last_freed = 32'd0;
      foreach (free_bit[i]) free_bit[i] = 0;
      foreach (order_of[i]) order_of[i] = 0;
      free_bit[0] = 1;
      free_bit[SM_NODES] = 1;
    endfunction

    // flat index of the free bit of block b at order k in pool p
    function int node_idx(int p, int k, int b);
      int hi;
      hi = p ? PG_HI : SM_HI;
      return (p ? SM_NODES : 0) + (1 << (hi - k)) - 1 + b;
    endfunction

    function alloc_result_t do_alloc(logic [31:0] sz);
      alloc_result_t r;
      logic [63:0] total;
      int order, p, lo, hi, k, b, j;
      logic [31:0] off;
      r.blk = 0;
      r.stat = STAT_NO_MEM;
      if (sz == 0) begin
        r.stat = STAT_ZERO;
        return r;
      end
      total = {32'd0, sz} + HDR;
      order = 0;
      while (total != 0) begin
        total = total >> 1;
        order++;
      end
      if (order < SM_LO) order = SM_LO;
      if (order > PG_HI) begin
        r.stat = STAT_TOO_LARGE;
        return r;
      end
      p = (order < PG_LO) ? 0 : 1;
      lo = p ? PG_LO : SM_LO;
      hi = p ? PG_HI : SM_HI;
      if (order < lo || order > hi) return r;
      // smallest order first, lowest address first
      for (k = order; k <= hi; k++) begin
        for (b = 0; b < (1 << (hi - k)); b++) begin
          if (free_bit[node_idx(p, k, b)]) begin
            free_bit[node_idx(p, k, b)] = 0;
            for (j = k; j > order; j--) begin
              b = b << 1;
              free_bit[node_idx(p, j - 1, b + 1)] = 1;
            end
            off = b << order;
            order_of[(p ? SM_SLOTS : 0) + (off >> lo)] = order;
            off = off + (p ? (32'd1 << SM_HI) : 32'd0);
            live_rel.push_back(off);
            r.blk = base + off + HDR;
            r.stat = STAT_OK;
            return r;
          end
        end
      end
      return r;
    endfunction

    function logic [2:0] do_free(logic [31:0] a);
      logic [31:0] rel, off;
      int p, lo, hi, k, b, slot;
      rel = a - base - HDR;
      if (rel < (32'd1 << SM_HI)) begin
        p = 0;
        off = rel;
      end else if (rel - (32'd1 << SM_HI) < (32'd1 << PG_HI)) begin
        p = 1;
        off = rel - (32'd1 << SM_HI);
      end else begin
        return STAT_BAD_FREE;
      end
      lo = p ? PG_LO : SM_LO;
      hi = p ? PG_HI : SM_HI;
      if ((off & ((32'd1 << lo) - 1)) != 0) return STAT_BAD_FREE;
      slot = (p ? SM_SLOTS : 0) + (off >> lo);
      k = order_of[slot];
      if (k < lo || k > hi) return STAT_BAD_FREE;
      if ((off & ((32'd1 << k) - 1)) != 0) return STAT_BAD_FREE;
      order_of[slot] = 0;
      // merge upward while the true buddy is free
      b = off >> k;
      while (k < hi) begin
        if (!free_bit[node_idx(p, k, b ^ 1)]) break;
        free_bit[node_idx(p, k, b ^ 1)] = 0;
        b = b >> 1;
        k++;
      end
      free_bit[node_idx(p, k, b)] = 1;
      foreach (live_rel[i]) begin
        if (live_rel[i] == rel) begin
          live_rel.delete(i);
          break;
        end
      end
      last_freed = rel;
      return STAT_OK;
    endfunction

    function void note_request(logic op, logic [31:0] sz, logic [31:0] a);
      alloc_result_t r;
      if (op == OP_ALLOC) begin
        r = do_alloc(sz);
      end else begin
        r.blk = 0;
        r.stat = do_free(a);
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] blk, logic [2:0] stat);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: block_addr %h status %0d", blk, stat);
        fails++;
        return;
      end
      e = pending_q.pop_front();
      if (blk !== e.blk) begin
        $error("block_addr: expected %h, got %h", e.blk, blk);
        fails++;
      end
      if (stat !== e.stat) begin
        $error("status: expected %0d, got %0d", e.stat, stat);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst;
  logic        in_valid, in_stall, req_type;
  logic [31:0] size, addr;
  logic        out_valid, out_stall;
  logic [31:0] block_addr;
  logic [2:0]  status;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  alloc_scoreboard sb = new();
  int send_idle_pct, recv_stall_pct;
  int cycles;

  buddy_block_allocator DUT (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(block_addr, status);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // present one request and hold it until accepted
  task automatic send_request(logic op, logic [31:0] sz, logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= op;
    size <= sz;
    addr <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, sz, a);
  endtask

  task automatic write_base(logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.base = v;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] live_addr();
    return sb.base + sb.live_rel[$urandom_range(sb.live_rel.size() - 1)] + HDR;
  endfunction

  // one random request, mostly well-formed alloc/free traffic
  task automatic random_request();
    int r;
    logic [31:0] sz;
    r = $urandom_range(99);
    if (sb.live_rel.size() > 80) r = 50;
    if (r < 45 || (r < 85 && sb.live_rel.size() == 0)) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: sz = $urandom_range(1, 4083) >> $urandom_range(11);
        5: sz = $urandom_range(200000, 1048563);
        6, 7, 8, 9: sz = $urandom_range(4084, 60000);
        default: sz = $urandom_range(1, 2000);
      endcase
      if (sz == 0) sz = 1;
      send_request(OP_ALLOC, sz, $urandom);
    end else if (r < 85) begin
      send_request(OP_FREE, $urandom, live_addr());
    end else if (r < 89) begin
      send_request(OP_FREE, $urandom, $urandom);
    end else if (r < 91) begin
      send_request(OP_FREE, $urandom, sb.base + sb.last_freed + HDR);
    end else if (r < 93 && sb.live_rel.size() != 0) begin
      send_request(OP_FREE, $urandom, live_addr() + $urandom_range(1, 4095));
    end else if (r < 96) begin
      send_request(OP_ALLOC, 32'd0, $urandom);
    end else begin
      send_request(OP_ALLOC, $urandom_range(1048564, 32'hFFFFFFFF), $urandom);
    end
  endtask

  initial begin
    int bases[4];
    cycles <= 0;
    rst <= 1;
    in_valid <= 0;
    req_type <= OP_ALLOC;
    size <= 0;
    addr <= 0;
    out_stall <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= 0;
    pwdata <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    write_base(32'h0);

    // directed: size edges, order boundaries, whole page pool, bad frees
    send_request(OP_ALLOC, 32'd0, 32'hFFFFFFFF);
    send_request(OP_ALLOC, 32'd1, 32'h0);
    send_request(OP_ALLOC, 32'd20, 32'h0);
    send_request(OP_ALLOC, 32'd21, 32'h0);
    send_request(OP_ALLOC, 32'd4083, 32'h0);
    send_request(OP_ALLOC, 32'd4084, 32'h0);
    send_request(OP_FREE, 32'h0, 32'd12 + (32'd1 << 16));
    send_request(OP_FREE, 32'h0, 32'd12 + (32'd1 << 16));
    send_request(OP_FREE, 32'h0, 32'd12 + (32'd1 << 16) + 32'd8192);
    send_request(OP_ALLOC, 32'd1048563, 32'h0);
    send_request(OP_ALLOC, 32'd1048563, 32'h0);
    send_request(OP_FREE, 32'hFFFFFFFF, 32'd12 + (32'd1 << 16));
    send_request(OP_ALLOC, 32'd1048563, 32'h0);
    send_request(OP_ALLOC, 32'd1048564, 32'h0);
    send_request(OP_ALLOC, 32'hFFFFFFFF, 32'h0);
    send_request(OP_FREE, 32'h0, 32'd0);
    send_request(OP_FREE, 32'h0, 32'hFFFFFFFF);
    send_request(OP_FREE, 32'h0, 32'd13);
    send_request(OP_FREE, 32'h0, 32'd12);
    send_request(OP_FREE, 32'h0, 32'd44);
    send_request(OP_ALLOC, 32'd52, 32'h0);
    drain();

    // random phases with different idling, stalling and base settings
    bases[0] = 32'hFFFFFFFF;
    bases[1] = $urandom;
    bases[2] = 32'hFFFFF000;
    bases[3] = 32'h0;
    for (int ph = 0; ph < 4; ph++) begin
      write_base(bases[ph]);
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 16 : 49) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 16 : 49) : 0;
      for (int n = 0; n < 300; n++) random_request();
      drain();
    end

    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_pool.sv
src/buddy_block_allocator.sv
test/buddy_block_allocator_tb.sv
